>>> sv/hir_pkg.sv
// Shared types, constants and helpers for the hyperspectral interleave reorder core.
// No dependencies; every other file refers to this package by scoped names.
package hir_pkg;

  // element width of the cube samples carried on the 16-bit value port
  localparam int ELEM_BITS = 16;
  localparam logic [15:0] VALUE_MASK =
      (ELEM_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << ELEM_BITS) - 64'd1);

  // largest legal cube dimensions
  localparam logic [11:0] MAX_SAMPLES = 12'd2048;
  localparam logic [11:0] MAX_LINES   = 12'd2048;
  localparam logic [11:0] MAX_BANDS   = 12'd512;

  // configuration register word indexes
  localparam logic [2:0] REG_SAMPLES = 3'd0;
  localparam logic [2:0] REG_LINES   = 3'd1;
  localparam logic [2:0] REG_BANDS   = 3'd2;
  localparam logic [2:0] REG_SRC     = 3'd3;
  localparam logic [2:0] REG_TGT     = 3'd4;

  typedef enum logic [1:0] {
    ORD_BSQ = 2'd0,
    ORD_BIL = 2'd1,
    ORD_BIP = 2'd2
  } order_e;

  typedef struct packed {
    logic [11:0] samples;
    logic [11:0] lines;
    logic [9:0]  bands;
  } cube_geom_t;

  typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    logic [8:0]  band;
  } cube_pos_t;

  // a zero count acts as one, an oversized count saturates
  function automatic logic [11:0] eff_count(logic [11:0] v, logic [11:0] hi);
    logic [11:0] r;
    if (v == 12'd0) begin
      r = 12'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // the unused order code falls back to band-sequential
  function automatic order_e eff_order(logic [1:0] v);
    order_e r;
    case (v)
      2'd1:    r = ORD_BIL;
      2'd2:    r = ORD_BIP;
      default: r = ORD_BSQ;
    endcase
    return r;
  endfunction

endpackage

>>> sv/hyperspectral_interleave_reorder_core.sv
// Top level of the hyperspectral interleave reorder core: APB registers, scan, index pipe.
// Depends on hir_pkg, hir_scan and hir_index_pipe.
//
// The core accepts cube elements in the source interleave (bsq, bil or bip) and returns
// each one with its element index in the target interleave, ready to drive the write
// address of a reorder buffer. One transaction is accepted per clock while in_stall_o
// is low. An accepted transaction lands in the input register and moves into the result
// register once that is free, and the result register offers it. While a result waits
// for its consumer the input register takes one more transaction, then in_stall_o rises.
// The rate is set by the scan counter update, which completes in the accepting cycle;
// the index sum (two multiplies and two adds) sits between the input and result registers.
// A transaction with cube_start set restarts the scan at row, column and band zero;
// cube_last flags the final element, after which the counters wrap on their own.
// Program geometry and orders over APB only while no transaction is in flight. Counts of
// zero act as one, counts above range saturate, and order code 3 acts as bsq.
module hyperspectral_interleave_reorder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // element input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_value_i,
  input  logic        cube_start_i,
  // result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] target_index_o,
  output logic [15:0] value_out_o,
  output logic        cube_last_o
);

  logic [11:0] samples_q;
  logic [11:0] lines_q;
  logic [9:0]  bands_q;
  logic [1:0]  src_q;
  logic [1:0]  tgt_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  hir_pkg::cube_geom_t geom;
  hir_pkg::order_e     src_ord, tgt_ord;
  hir_pkg::cube_pos_t  pos;
  logic                in_accept;
  logic                scan_last;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  // register writes; addresses past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= 12'd1;
      lines_q   <= 12'd1;
      bands_q   <= 10'd1;
      src_q     <= 2'd0;
      tgt_q     <= 2'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        hir_pkg::REG_SAMPLES: samples_q <= pwdata[11:0];
        hir_pkg::REG_LINES:   lines_q   <= pwdata[11:0];
        hir_pkg::REG_BANDS:   bands_q   <= pwdata[9:0];
        hir_pkg::REG_SRC:     src_q     <= pwdata[1:0];
        hir_pkg::REG_TGT:     tgt_q     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hir_pkg::REG_SAMPLES: prdata = {20'd0, samples_q};
      hir_pkg::REG_LINES:   prdata = {20'd0, lines_q};
      hir_pkg::REG_BANDS:   prdata = {22'd0, bands_q};
      hir_pkg::REG_SRC:     prdata = {30'd0, src_q};
      hir_pkg::REG_TGT:     prdata = {30'd0, tgt_q};
      default:              prdata = 32'd0;
    endcase
  end

  // clamp the programmed geometry into its legal range
  always_comb begin
    geom.samples = hir_pkg::eff_count(samples_q, hir_pkg::MAX_SAMPLES);
    geom.lines   = hir_pkg::eff_count(lines_q, hir_pkg::MAX_LINES);
    geom.bands   = 10'(hir_pkg::eff_count({2'b00, bands_q}, hir_pkg::MAX_BANDS));
  end

  assign src_ord   = hir_pkg::eff_order(src_q);
  assign tgt_ord   = hir_pkg::eff_order(tgt_q);
  assign in_accept = in_valid_i && !in_stall_o;

  // advance the scan once per accepted transaction
  hir_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .start_i  (cube_start_i),
    .geom_i   (geom),
    .src_i    (src_ord),
    .pos_o    (pos),
    .last_o   (scan_last)
  );

  hir_index_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pos_i       (pos),
    .geom_i      (geom),
    .tgt_i       (tgt_ord),
    .value_i     (sample_value_i & hir_pkg::VALUE_MASK),
    .last_i      (scan_last),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .index_o     (target_index_o),
    .value_o     (value_out_o),
    .last_o      (cube_last_o)
  );

endmodule

>>> sv/hir_scan.sv
// Row, column and band scan counters that step in the arrival interleave order.
// Depends on hir_pkg for the geometry and position types and the order codes.
module hir_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                start_i,
  input  hir_pkg::cube_geom_t geom_i,
  input  hir_pkg::order_e     src_i,
  output hir_pkg::cube_pos_t  pos_o,
  output logic                last_o
);

  logic [10:0] row_q, row_d;
  logic [10:0] col_q, col_d;
  logic [8:0]  band_q, band_d;
  hir_pkg::cube_pos_t cur;
  logic wrap_r, wrap_c, wrap_b;
  logic [10:0] row_nx, col_nx;
  logic [8:0]  band_nx;

  always_comb begin
    // restart the scan on a cube start
    cur.row  = start_i ? 11'd0 : row_q;
    cur.col  = start_i ? 11'd0 : col_q;
    cur.band = start_i ? 9'd0  : band_q;

    wrap_r = ({1'b0, cur.row} + 12'd1) >= geom_i.lines;
    wrap_c = ({1'b0, cur.col} + 12'd1) >= geom_i.samples;
    wrap_b = ({1'b0, cur.band} + 10'd1) >= geom_i.bands;

    row_nx  = wrap_r ? 11'd0 : cur.row + 11'd1;
    col_nx  = wrap_c ? 11'd0 : cur.col + 11'd1;
    band_nx = wrap_b ? 9'd0  : cur.band + 9'd1;

    row_d  = cur.row;
    col_d  = cur.col;
    band_d = cur.band;
    case (src_i)
      hir_pkg::ORD_BIL: begin
        col_d = col_nx;
        if (wrap_c) band_d = band_nx;
        if (wrap_c && wrap_b) row_d = row_nx;
      end
      hir_pkg::ORD_BIP: begin
        band_d = band_nx;
        if (wrap_b) col_d = col_nx;
        if (wrap_b && wrap_c) row_d = row_nx;
      end
      default: begin
        col_d = col_nx;
        if (wrap_c) row_d = row_nx;
        if (wrap_c && wrap_r) band_d = band_nx;
      end
    endcase
  end

  assign pos_o  = cur;
  assign last_o = wrap_r && wrap_c && wrap_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= 11'd0;
      col_q  <= 11'd0;
      band_q <= 9'd0;
    end else if (accept_i) begin
      row_q  <= row_d;
      col_q  <= col_d;
      band_q <= band_d;
    end
  end

  // the last element of a cube wraps every counter
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_o) |=> (row_q == 11'd0 && col_q == 11'd0 && band_q == 9'd0))
    else $error("scan counters did not wrap after the last element");

endmodule

>>> sv/hir_index_pipe.sv
// Input register and result register that turn a scan position into a target interleave index.
// Depends on hir_pkg for the geometry and position types and the order codes.
module hir_index_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hir_pkg::cube_pos_t  pos_i,
  input  hir_pkg::cube_geom_t geom_i,
  input  hir_pkg::order_e     tgt_i,
  input  logic [15:0]         value_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [30:0]         index_o,
  output logic [15:0]         value_o,
  output logic                last_o
);

  logic en1, en2;

  // input register: operands of the index sum a*x + y*z + w
  logic        v1_q;
  logic [10:0] a1_q, a1_d;
  logic [23:0] x1_q, x1_d;
  logic [10:0] y1_q, y1_d;
  logic [11:0] z1_q, z1_d;
  logic [10:0] w1_q, w1_d;
  logic [15:0] val1_q;
  logic        last1_q;
  logic [11:0] m_sel;

  // result register
  logic        v2_q;
  logic [30:0] idx2_q;
  logic [15:0] val2_q;
  logic        last2_q;
  logic [30:0] idx_d;

  assign en2 = !v2_q || !out_stall_i;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // pick the operands for the target order and form the outer stride (band plane for bsq, line for bil and bip)
  always_comb begin
    case (tgt_i)
      hir_pkg::ORD_BIL: begin
        a1_d  = pos_i.row;
        m_sel = {2'b00, geom_i.bands};
        y1_d  = {2'b00, pos_i.band};
        z1_d  = geom_i.samples;
        w1_d  = pos_i.col;
      end
      hir_pkg::ORD_BIP: begin
        a1_d  = pos_i.row;
        m_sel = {2'b00, geom_i.bands};
        y1_d  = pos_i.col;
        z1_d  = {2'b00, geom_i.bands};
        w1_d  = {2'b00, pos_i.band};
      end
      default: begin
        a1_d  = {2'b00, pos_i.band};
        m_sel = geom_i.lines;
        y1_d  = pos_i.row;
        z1_d  = geom_i.samples;
        w1_d  = pos_i.col;
      end
    endcase
    x1_d = 24'(geom_i.samples) * 24'(m_sel);
  end

  // index wraps at 31 bits
  assign idx_d = 31'(a1_q) * 31'(x1_q) + 31'(y1_q) * 31'(z1_q) + 31'(w1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      a1_q    <= a1_d;
      x1_q    <= x1_d;
      y1_q    <= y1_d;
      z1_q    <= z1_d;
      w1_q    <= w1_d;
      val1_q  <= value_i;
      last1_q <= last_i;
    end
    if (en2 && v1_q) begin
      idx2_q  <= idx_d;
      val2_q  <= val1_q;
      last2_q <= last1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign index_o     = idx2_q;
  assign value_o     = val2_q;
  assign last_o      = last2_q;

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v2_q |-> !in_stall_o)
    else $error("input stalled with an empty result register");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted transaction missing from the input register");

  a_drain_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !v2_q) |=> v2_q)
    else $error("transaction lost between the input register and the result register");

endmodule
